FILE: rtl/sle_pkg.sv
// Shared types, constants and control structs for the serial line editor.
`timescale 1ns / 1ps

package sle_pkg;

   localparam int LINE_DEPTH_DEFAULT = 32;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_BELL  = 8'd7;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DEL   = 8'd127;

   localparam logic [1:0] CHAN_ECHO = 2'd0;
   localparam logic [1:0] CHAN_LINE = 2'd1;
   localparam logic [1:0] CHAN_EOL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ECHO_RX,
      ST_BELL,
      ST_BS1,
      ST_BS2,
      ST_BS3,
      ST_CR1,
      ST_CR2,
      ST_LINE_START,
      ST_LINE_FETCH,
      ST_LINE_EMIT,
      ST_EOL
   } state_type;

   typedef enum logic [2:0] {
      SEL_RX,
      SEL_CR,
      SEL_LF,
      SEL_BS,
      SEL_SPACE,
      SEL_BELL,
      SEL_MEM,
      SEL_ZERO
   } byte_sel_type;

   typedef enum logic [1:0] {
      RX_NONE,
      RX_CR,
      RX_ERASE,
      RX_CHAR
   } rx_class_type;

   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_INC,
      LEN_DEC,
      LEN_CLEAR
   } len_op_type;

   typedef struct packed {
      logic         capture;
      logic         store_wr;
      len_op_type   len_op;
      logic         rd_clear;
      logic         rd_advance;
      logic         emit;
      byte_sel_type emit_sel;
      logic [1:0]   emit_chan;
      logic         emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      rx_class_type rx_class;
      logic         len_zero;
      logic         line_full;
      logic         echo_on;
      logic         rd_last;
      logic         out_free;
   } dp_status_type;

endpackage

FILE: rtl/sle_ctrl.sv
// Sequencer that decodes each received byte and steps through its result beats.
`timescale 1ns / 1ps

module sle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sle_pkg::dp_status_type status,
   output sle_pkg::ctrl_cmd_type  cmd
);
   import sle_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.capture    = 1'b0;
      cmd.store_wr   = 1'b0;
      cmd.len_op     = LEN_HOLD;
      cmd.rd_clear   = 1'b0;
      cmd.rd_advance = 1'b0;
      cmd.emit       = 1'b0;
      cmd.emit_sel   = SEL_ZERO;
      cmd.emit_chan  = CHAN_ECHO;
      cmd.emit_last  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.rx_class)
               RX_NONE: begin
                  state_in = ST_IDLE;
               end
               RX_CR: begin
                  state_in = status.echo_on ? ST_CR1 : ST_LINE_START;
               end
               RX_ERASE: begin
                  if (status.len_zero) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.len_op = LEN_DEC;
                     state_in   = status.echo_on ? ST_BS1 : ST_IDLE;
                  end
               end
               RX_CHAR: begin
                  if (status.line_full) begin
                     state_in = status.echo_on ? ST_BELL : ST_IDLE;
                  end else begin
                     cmd.store_wr = 1'b1;
                     cmd.len_op   = LEN_INC;
                     state_in     = status.echo_on ? ST_ECHO_RX : ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_ECHO_RX: begin
            cmd.emit_sel  = SEL_RX;
            cmd.emit_last = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_BELL: begin
            cmd.emit_sel  = SEL_BELL;
            cmd.emit_last = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_BS1: begin
            cmd.emit_sel = SEL_BS;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_BS2;
            end
         end
         ST_BS2: begin
            cmd.emit_sel = SEL_SPACE;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_BS3;
            end
         end
         ST_BS3: begin
            cmd.emit_sel  = SEL_BS;
            cmd.emit_last = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CR1: begin
            cmd.emit_sel = SEL_CR;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CR2;
            end
         end
         ST_CR2: begin
            cmd.emit_sel = SEL_LF;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LINE_START;
            end
         end
         ST_LINE_START: begin
            cmd.rd_clear = 1'b1;
            state_in     = status.len_zero ? ST_EOL : ST_LINE_FETCH;
         end
         ST_LINE_FETCH: begin
            state_in = ST_LINE_EMIT;
         end
         ST_LINE_EMIT: begin
            cmd.emit_sel  = SEL_MEM;
            cmd.emit_chan = CHAN_LINE;
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.rd_advance = 1'b1;
               state_in       = status.rd_last ? ST_EOL : ST_LINE_FETCH;
            end
         end
         ST_EOL: begin
            cmd.emit_sel  = SEL_ZERO;
            cmd.emit_chan = CHAN_EOL;
            cmd.emit_last = 1'b1;
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.len_op = LEN_CLEAR;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/sle_dp.sv
// Datapath: received byte, line store, length, read pointer and output register.
`timescale 1ns / 1ps

module sle_dp #(
   parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast,
   input  sle_pkg::ctrl_cmd_type  cmd,
   output sle_pkg::dp_status_type status
);
   import sle_pkg::*;

   localparam int LEN_W = $clog2(LINE_DEPTH);

   logic [7:0]       mem [LINE_DEPTH];
   logic [7:0]       rx_ff;
   logic [7:0]       rd_data_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [LEN_W-1:0] rd_idx_ff;
   logic             echo_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic [1:0]       rsp_chan_ff;
   logic             rsp_last_ff;
   logic [7:0]       emit_byte;
   rx_class_type     rx_class;

   always_comb begin
      priority if (rx_ff == CH_NUL || rx_ff == CH_LF) begin
         rx_class = RX_NONE;
      end else if (rx_ff == CH_CR) begin
         rx_class = RX_CR;
      end else if (rx_ff == CH_BS || rx_ff == CH_DEL) begin
         rx_class = RX_ERASE;
      end else begin
         rx_class = RX_CHAR;
      end
   end

   always_comb begin
      unique case (cmd.emit_sel)
         SEL_RX:    emit_byte = rx_ff;
         SEL_CR:    emit_byte = CH_CR;
         SEL_LF:    emit_byte = CH_LF;
         SEL_BS:    emit_byte = CH_BS;
         SEL_SPACE: emit_byte = CH_SPACE;
         SEL_BELL:  emit_byte = CH_BELL;
         SEL_MEM:   emit_byte = rd_data_ff;
         SEL_ZERO:  emit_byte = 8'd0;
         default:   emit_byte = 8'd0;
      endcase
   end

   always_comb begin
      unique case (cmd.len_op)
         LEN_HOLD:  len_in = len_ff;
         LEN_INC:   len_in = len_ff + LEN_W'(1);
         LEN_DEC:   len_in = len_ff - LEN_W'(1);
         LEN_CLEAR: len_in = '0;
         default:   len_in = len_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         mem[len_ff] <= rx_ff;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rx_ff <= req_tdata;
      end
      if (cmd.rd_clear) begin
         rd_idx_ff <= '0;
      end else if (cmd.rd_advance) begin
         rd_idx_ff <= rd_idx_ff + LEN_W'(1);
      end
      if (cmd.emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_chan_ff <= cmd.emit_chan;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         echo_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         if (csr_valid) begin
            echo_ff <= csr_data;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.rx_class  = rx_class;
   assign status.len_zero  = (len_ff == '0);
   assign status.line_full = (len_ff == LEN_W'(LINE_DEPTH - 1));
   assign status.echo_on   = echo_ff;
   assign status.rd_last   = (rd_idx_ff == len_ff - LEN_W'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/serial_line_editor_core.sv
// Top level of the serial line editor: sequencer plus datapath.
// A new byte is accepted only after every result beat of the previous one has
// been written to the output register; output stalls hold the sequencer.
// Reset: synchronous; clears only FSM state, length, echo enable and output valid.
`timescale 1ns / 1ps

module serial_line_editor_core #(
   parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] channel
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // echo_enable
);
   import sle_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   sle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sle_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: rtl/sle_checker.sv
// Port-level assertions for the serial line editor, bound to the top level.
`timescale 1ns / 1ps

module sle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);
   import sle_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == CHAN_EOL |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("end-of-line beat without last or with nonzero data");

   a_chan_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == CHAN_ECHO || rsp_tuser == CHAN_LINE
         || rsp_tuser == CHAN_EOL)
      else $error("rsp beat with unknown channel");

   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("req ready while a result run is unfinished");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req ready right after an accepted beat");

endmodule

bind serial_line_editor_core sle_checker u_sle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: bench/tb_top.sv
// Self-checking bench for serial_line_editor_core: edits, echoes and line output.
`timescale 1ns / 1ps

module tb_top;
   import sle_pkg::*;

   localparam int DEPTH = LINE_DEPTH_DEFAULT;

   typedef struct packed {
      logic [1:0] chan;
      logic [7:0] data;
      logic       last;
   } editor_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_data = 1'b0;

   // predicted editor state
   logic [7:0]      line_chars [0:DEPTH-1];
   int              line_len = 0;
   logic            echo_on = 1'b0;
   editor_beat_type pending_beats [$];

   int error_count = 0;
   int counted_bytes = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   serial_line_editor_core #(.LINE_DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic void push_beat(input logic [1:0] chan, input logic [7:0] data);
      editor_beat_type beat;
      beat.chan = chan;
      beat.data = data;
      beat.last = 1'b0;
      pending_beats.push_back(beat);
   endfunction

   function automatic void edit_line(input logic [7:0] c);
      int depth_in;
      depth_in = pending_beats.size();
      if (c == CH_CR) begin
         if (echo_on) begin
            push_beat(CHAN_ECHO, CH_CR);
            push_beat(CHAN_ECHO, CH_LF);
         end
         for (int i = 0; i < line_len; i++)
            push_beat(CHAN_LINE, line_chars[i]);
         push_beat(CHAN_EOL, 8'h00);
         line_len = 0;
      end else if (c == CH_BS || c == CH_DEL) begin
         if (line_len > 0) begin
            if (echo_on) begin
               push_beat(CHAN_ECHO, CH_BS);
               push_beat(CHAN_ECHO, CH_SPACE);
               push_beat(CHAN_ECHO, CH_BS);
            end
            line_len--;
         end
      end else if (c != CH_NUL && c != CH_LF) begin
         if (line_len + 1 < DEPTH) begin
            if (echo_on)
               push_beat(CHAN_ECHO, c);
            line_chars[line_len] = c;
            line_len++;
         end else if (echo_on) begin
            push_beat(CHAN_ECHO, CH_BELL);
         end
      end
      if (pending_beats.size() > depth_in)
         pending_beats[pending_beats.size() - 1].last = 1'b1;
   endfunction

   // predict on accepted bytes and register writes, check each result beat
   always @(posedge clock) begin
      editor_beat_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            echo_on = csr_data;
         if (req_tvalid && req_tready)
            edit_line(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_beats.size() == 0) begin
               $display("%0t: unexpected beat chan=%0d byte=%02h last=%0b, none expected",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = pending_beats.pop_front();
               if (want.chan !== rsp_tuser || want.data !== rsp_tdata
                   || want.last !== rsp_tlast) begin
                  $display("%0t: mismatch exp %0d/%02h/%0b got %0d/%02h/%0b",
                           $time, want.chan, want.data, want.last,
                           rsp_tuser, rsp_tdata, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver: random back-pressure, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_left == 0 && hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (b != CH_NUL && b != CH_LF)
         counted_bytes++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_beats.size() != 0)
         @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_echo(input logic value);
      wait_idle();
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] ordinary_char();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == CH_NUL || b == CH_LF || b == CH_CR || b == CH_BS || b == CH_DEL);
      return b;
   endfunction

   task automatic test_reset_defaults();
      send_byte(8'h48);
      send_byte(CH_NUL);
      send_byte(CH_CR);
   endtask

   task automatic test_echo_edits();
      write_echo(1'b1);
      send_byte(CH_NUL);
      send_byte(CH_LF);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(8'h61);
      send_byte(8'h01);
      send_byte(CH_BELL);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h7E);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(CH_CR);
      send_byte(CH_CR);
   endtask

   task automatic test_silent_edits();
      write_echo(1'b0);
      send_byte(CH_SPACE);
      send_byte(8'h7A);
      send_byte(CH_BS);
      send_byte(8'hFE);
      send_byte(CH_CR);
      send_byte(CH_CR);
   endtask

   task automatic test_line_traffic(input int target);
      int start;
      int kind;
      int len;
      logic [7:0] b;
      start = counted_bytes;
      while (counted_bytes - start < target) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(36, 28) : $urandom_range(12);
            for (int i = 0; i < len; i++) begin
               kind = $urandom_range(99);
               if (kind < 85)
                  b = ordinary_char();
               else if (kind < 93)
                  b = $urandom_range(1) ? CH_BS : CH_DEL;
               else
                  b = $urandom_range(1) ? CH_NUL : CH_LF;
               send_byte(b);
            end
            send_byte(CH_CR);
         end else if (kind < 90) begin
            send_byte(8'($urandom_range(255)));
         end else if (kind < 95) begin
            repeat ($urandom_range(4, 1))
               send_byte($urandom_range(1) ? CH_BS : CH_DEL);
         end else begin
            repeat ($urandom_range(5, 1))
               send_byte(ordinary_char());
         end
      end
   endtask

   task automatic test_output_stall();
      write_echo(1'b1);
      hold_request = 400;
      repeat (34)
         send_byte(ordinary_char());
      send_byte(CH_CR);
   endtask

   initial begin
      send_idle_pct = 18;
      recv_idle_pct = 88;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_echo_edits();
      test_silent_edits();

      write_echo(1'b1);
      test_line_traffic(130);

      send_idle_pct = 88;
      recv_idle_pct = 18;
      write_echo(1'b0);
      test_line_traffic(130);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_echo(1'b0);
      test_line_traffic(55);
      write_echo(1'b1);
      test_line_traffic(60);
      test_output_stall();

      wait_idle();
      repeat (100) @(negedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
